@@ src/assert_macros.svh @@
// Assertion macros shared by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define TCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define TCB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ src/tcb_pkg.sv @@
// Constants, byte codes and address helpers of the text console.
package tcb_pkg;

  localparam int ROWS     = 25;
  localparam int COLS     = 80;
  localparam int CELLS    = ROWS * COLS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int SUM_W    = ROW_W + 1;
  localparam int CNT_W    = COL_W + 1;
  localparam int TAB_STEP = 8;
  localparam int TAB_W    = $clog2(TAB_STEP);

  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [SUM_W-1:0]  ROW_CNT  = SUM_W'(ROWS);
  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLS - 1);
  localparam logic [CNT_W-1:0]  COL_CNT  = CNT_W'(COLS);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Logical row to stored row, given the row currently shown on top.
  function automatic logic [ROW_W-1:0] row_phys(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] top);
    logic [SUM_W-1:0] s;
    s = {1'b0, row} + {1'b0, top};
    if (s >= ROW_CNT) begin
      s = s - ROW_CNT;
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

endpackage

@@ src/tcb_ifs.sv @@
// Valid/ready channels of the text console: item input and result output.
interface tcb_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [7:0]               data_byte;
  logic [tcb_pkg::ROW_W-1:0] read_row;
  logic [tcb_pkg::COL_W-1:0] read_col;

  modport source (output valid, kind, data_byte, read_row, read_col, input ready);
  modport sink   (input valid, kind, data_byte, read_row, read_col, output ready);
endinterface

interface tcb_out_if;
  logic                     valid;
  logic                     ready;
  logic [tcb_pkg::ROW_W-1:0] cursor_row;
  logic [tcb_pkg::COL_W-1:0] cursor_col;
  logic [7:0]               read_char;
  logic                     bell;
  logic                     scrolled;

  modport source (output valid, cursor_row, cursor_col, read_char, bell, scrolled,
                  input ready);
  modport sink   (input valid, cursor_row, cursor_col, read_char, bell, scrolled,
                  output ready);
endinterface

@@ src/text_console_byte_handler.sv @@
// Text console top level: character store, cursor and item sequencer.
//
// items: one beat per received byte (kind 0) or character read (kind 1).
// results: one beat per item with cursor, read character, bell and scroll.
// The 25 x 80 store lives in one synchronous RAM (one write, one read per
// cycle). Scrolling moves a top-row pointer and blanks the recycled row.
// Path from item beat to result beat: a plain byte, CR, LF, BS, BEL or ESC
// goes from idle straight to the done state; a read passes the read state
// (the RAM read) first; a tab pads one cell per visit to the tab state;
// any scroll adds the blanking state, one RAM write per each of the 80 cells.
// The next item is taken once the result is in the output register, so a
// stalled receiver holds only that register; a second result waits inside.
// Reset: cursor and top row go to 0 and a clearing pass writes spaces to
// all 2000 cells, one per cycle; no item is taken until the pass ends.
`include "assert_macros.svh"

module text_console_byte_handler (
  input logic      clk,
  input logic      rst,
  tcb_in_if.sink   items,
  tcb_out_if.source results
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_TAB   = 6'b000100,
    S_BLANK = 6'b001000,
    S_READ  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                       state;
  logic [tcb_pkg::ROW_W-1:0]    crow;
  logic [tcb_pkg::COL_W-1:0]    ccol;
  logic [tcb_pkg::ROW_W-1:0]    top;
  logic [tcb_pkg::ADDR_W-1:0]   clr_addr;
  logic [tcb_pkg::COL_W-1:0]    bcol;
  logic                         rd_ok;
  logic [7:0]                   res_char;
  logic                         bell_q;
  logic                         scroll_q;

  logic [7:0]                   mem [tcb_pkg::CELLS];
  logic [7:0]                   rdata;

  logic                         we;
  logic                         re;
  logic [tcb_pkg::ADDR_W-1:0]   waddr;
  logic [7:0]                   wdata;
  logic [tcb_pkg::ADDR_W-1:0]   raddr;

  logic [tcb_pkg::ROW_W-1:0]    cur_prow;
  logic [tcb_pkg::CNT_W-1:0]    col_inc;
  logic                         wrap;
  logic                         at_bottom;
  logic [tcb_pkg::COL_W-1:0]    adv_col;
  logic [tcb_pkg::ROW_W-1:0]    adv_row;
  logic                         adv_scroll;
  logic [tcb_pkg::ROW_W-1:0]    top_inc;
  logic                         printable;
  logic                         rd_in_range;
  logic                         idle_scroll;
  logic                         tab_pad;

  assign items.ready = (state == S_IDLE);

  assign cur_prow   = tcb_pkg::row_phys(crow, top);
  assign col_inc    = {1'b0, ccol} + tcb_pkg::CNT_W'(1);
  assign wrap       = (col_inc == tcb_pkg::COL_CNT);
  assign at_bottom  = (crow == tcb_pkg::ROW_LAST);
  assign adv_col    = wrap ? '0 : col_inc[tcb_pkg::COL_W-1:0];
  assign adv_row    = (wrap && !at_bottom) ? crow + tcb_pkg::ROW_W'(1) : crow;
  assign adv_scroll = wrap && at_bottom;
  assign top_inc    = (top == tcb_pkg::ROW_LAST) ? '0 : top + tcb_pkg::ROW_W'(1);

  assign printable = (items.data_byte != tcb_pkg::CH_LF)  &&
                     (items.data_byte != tcb_pkg::CH_CR)  &&
                     (items.data_byte != tcb_pkg::CH_TAB) &&
                     (items.data_byte != tcb_pkg::CH_BEL) &&
                     (items.data_byte != tcb_pkg::CH_BS)  &&
                     (items.data_byte != tcb_pkg::CH_ESC);

  assign idle_scroll = !items.kind &&
                       (((items.data_byte == tcb_pkg::CH_LF) && at_bottom) ||
                        (printable && adv_scroll));
  assign tab_pad     = !items.kind && (items.data_byte == tcb_pkg::CH_TAB) &&
                       (ccol[tcb_pkg::TAB_W-1:0] != '0);

  assign rd_in_range = ({1'b0, items.read_row} < tcb_pkg::ROW_CNT) &&
                       ({1'b0, items.read_col} < tcb_pkg::COL_CNT);

  assign re    = (state == S_IDLE) && items.valid && items.kind && rd_in_range;
  assign raddr = tcb_pkg::cell_addr(tcb_pkg::row_phys(items.read_row, top),
                                    items.read_col);

  // Single write port
  always_comb begin
    we    = 1'b0;
    waddr = tcb_pkg::cell_addr(cur_prow, ccol);
    wdata = tcb_pkg::CH_SPACE;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      S_IDLE: begin
        if (items.valid && !items.kind) begin
          if (items.data_byte == tcb_pkg::CH_BS) begin
            we    = (ccol != '0);
            waddr = tcb_pkg::cell_addr(cur_prow, ccol - tcb_pkg::COL_W'(1));
          end else if (printable) begin
            we    = 1'b1;
            wdata = items.data_byte;
          end
        end
      end
      S_TAB: begin
        we = 1'b1;
      end
      S_BLANK: begin
        we    = 1'b1;
        waddr = tcb_pkg::cell_addr(cur_prow, bcol);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      crow          <= '0;
      ccol          <= '0;
      top           <= '0;
      clr_addr      <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && (state != S_DONE)) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + tcb_pkg::ADDR_W'(1);
          if (clr_addr == tcb_pkg::CELL_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (items.valid) begin
            res_char <= '0;
            rd_ok    <= rd_in_range;
            bell_q   <= !items.kind && (items.data_byte == tcb_pkg::CH_BEL);
            scroll_q <= idle_scroll;
            if (idle_scroll) begin
              top  <= top_inc;
              bcol <= '0;
            end
            priority if (items.kind) begin
              state <= S_READ;
            end else if (idle_scroll) begin
              state <= S_BLANK;
            end else if (tab_pad) begin
              state <= S_TAB;
            end else begin
              state <= S_DONE;
            end
            if (!items.kind) begin
              unique case (items.data_byte)
                tcb_pkg::CH_LF: begin
                  if (!at_bottom) begin
                    crow <= crow + tcb_pkg::ROW_W'(1);
                  end
                end
                tcb_pkg::CH_CR: begin
                  ccol <= '0;
                end
                tcb_pkg::CH_BS: begin
                  if (ccol != '0) begin
                    ccol <= ccol - tcb_pkg::COL_W'(1);
                  end
                end
                tcb_pkg::CH_TAB, tcb_pkg::CH_BEL, tcb_pkg::CH_ESC: begin
                end
                default: begin
                  ccol <= adv_col;
                  crow <= adv_row;
                end
              endcase
            end
          end
        end
        S_TAB: begin
          ccol <= adv_col;
          crow <= adv_row;
          if (adv_scroll) begin
            top      <= top_inc;
            scroll_q <= 1'b1;
            bcol     <= '0;
            state    <= S_BLANK;
          end else if (adv_col[tcb_pkg::TAB_W-1:0] == '0) begin
            state <= S_DONE;
          end
        end
        S_BLANK: begin
          bcol <= bcol + tcb_pkg::COL_W'(1);
          if (bcol == tcb_pkg::COL_LAST) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          res_char <= rd_ok ? rdata : '0;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!results.valid || results.ready) begin
            results.valid      <= 1'b1;
            results.cursor_row <= crow;
            results.cursor_col <= ccol;
            results.read_char  <= res_char;
            results.bell       <= bell_q;
            results.scrolled   <= scroll_q;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TCB_ASSERT(a_cursor_range, (crow <= tcb_pkg::ROW_LAST) && (ccol <= tcb_pkg::COL_LAST), "cursor out of range")
  `TCB_ASSERT(a_top_range, top <= tcb_pkg::ROW_LAST, "top row pointer out of range")
  `TCB_ASSERT(a_blank_bottom, (state == S_BLANK) |-> (crow == tcb_pkg::ROW_LAST), "blanking off the bottom row")
  `TCB_ASSERT_ALWAYS(a_clear_after_rst, $past(rst) |-> (state == S_CLEAR), "no clearing pass after reset")

endmodule
